// ===== hw/rtl/rlss_pkg.sv =====
// ============================================================================
// rlss_pkg
// Shared types and constants of the rate limited setpoint smoother: register
// reset values and indexes, controller states and datapath commands.
// ============================================================================
`default_nettype none

package rlss_pkg;

   localparam int POS_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SMOOTHING_GAIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_LIMIT     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS  = 2'd2;

   localparam logic [15:0] GAIN_RESET    = 16'd3277;
   localparam logic [23:0] LIMIT_RESET   = 24'd300000;
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   // Operation codes of an input item.
   localparam logic OP_TARGET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 24;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIFF,
      ST_GMUL,
      ST_GEND,
      ST_CHECK,
      ST_SQ,
      ST_SQCMP,
      ST_NORM,
      ST_RSQ,
      ST_ROOTINIT,
      ST_ROOT,
      ST_CEIL,
      ST_DIVINIT,
      ST_DIV,
      ST_DIVEND,
      ST_APPLY
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_PREP,
      DP_DIFF,
      DP_GMUL,
      DP_GEND,
      DP_CHECK,
      DP_SQ,
      DP_SQCMP,
      DP_NORM,
      DP_RSQ,
      DP_ROOTINIT,
      DP_ROOT,
      DP_CEIL,
      DP_DIVINIT,
      DP_DIV,
      DP_DIVEND,
      DP_APPLY
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic over_limit;
      logic sum_over;
      logic need_shift;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rlss_ctrl.sv =====
// ============================================================================
// rlss_ctrl
// Sequencer of the smoother: captures one item and walks a tick through difference,
// gain, length check, for a limited step normalization, square root and division, and update.
// ============================================================================
`default_nettype none

module rlss_ctrl #(
   parameter int POS_WIDTH = rlss_pkg::POS_WIDTH_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output rlss_pkg::dp_cmd_type   dp_cmd,
   input  rlss_pkg::dp_status_type dp_status
);

   localparam int NCH = (POS_WIDTH + 1 + 15) / 16;

   rlss_pkg::state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlss_pkg::ST_IDLE;
         axis_ff  <= 2'd0;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cnt_in      = cnt_ff;
      req_tready  = 1'b0;
      dp_cmd.op   = rlss_pkg::DP_NOP;
      dp_cmd.axis = axis_ff;
      case (state_ff)
         rlss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.op = rlss_pkg::DP_CAPTURE;
               state_in  = rlss_pkg::ST_PREP;
            end
         end
         rlss_pkg::ST_PREP: begin
            dp_cmd.op = rlss_pkg::DP_PREP;
            axis_in   = 2'd0;
            state_in  = dp_status.is_tick ? rlss_pkg::ST_DIFF : rlss_pkg::ST_IDLE;
         end
         rlss_pkg::ST_DIFF: begin
            dp_cmd.op = rlss_pkg::DP_DIFF;
            cnt_in    = 5'(NCH - 1);
            state_in  = rlss_pkg::ST_GMUL;
         end
         rlss_pkg::ST_GMUL: begin
            dp_cmd.op = rlss_pkg::DP_GMUL;
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = rlss_pkg::ST_GEND;
            end
         end
         rlss_pkg::ST_GEND: begin
            dp_cmd.op = rlss_pkg::DP_GEND;
            if (axis_ff == 2'd2) begin
               state_in = rlss_pkg::ST_CHECK;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = rlss_pkg::ST_DIFF;
            end
         end
         rlss_pkg::ST_CHECK: begin
            dp_cmd.op = rlss_pkg::DP_CHECK;
            axis_in   = 2'd0;
            state_in  = dp_status.over_limit ? rlss_pkg::ST_NORM : rlss_pkg::ST_SQ;
         end
         rlss_pkg::ST_SQ: begin
            dp_cmd.op = rlss_pkg::DP_SQ;
            if (axis_ff == 2'd2) begin
               state_in = rlss_pkg::ST_SQCMP;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         rlss_pkg::ST_SQCMP: begin
            dp_cmd.op = rlss_pkg::DP_SQCMP;
            state_in  = dp_status.sum_over ? rlss_pkg::ST_NORM : rlss_pkg::ST_APPLY;
         end
         rlss_pkg::ST_NORM: begin
            dp_cmd.op = rlss_pkg::DP_NORM;
            axis_in   = 2'd0;
            if (!dp_status.need_shift) begin
               state_in = rlss_pkg::ST_RSQ;
            end
         end
         rlss_pkg::ST_RSQ: begin
            dp_cmd.op = rlss_pkg::DP_RSQ;
            if (axis_ff == 2'd2) begin
               state_in = rlss_pkg::ST_ROOTINIT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         rlss_pkg::ST_ROOTINIT: begin
            dp_cmd.op = rlss_pkg::DP_ROOTINIT;
            cnt_in    = 5'(rlss_pkg::ROOT_STEPS - 1);
            state_in  = rlss_pkg::ST_ROOT;
         end
         rlss_pkg::ST_ROOT: begin
            dp_cmd.op = rlss_pkg::DP_ROOT;
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = rlss_pkg::ST_CEIL;
            end
         end
         rlss_pkg::ST_CEIL: begin
            dp_cmd.op = rlss_pkg::DP_CEIL;
            axis_in   = 2'd0;
            state_in  = rlss_pkg::ST_DIVINIT;
         end
         rlss_pkg::ST_DIVINIT: begin
            dp_cmd.op = rlss_pkg::DP_DIVINIT;
            cnt_in    = 5'(rlss_pkg::DIV_STEPS - 1);
            state_in  = rlss_pkg::ST_DIV;
         end
         rlss_pkg::ST_DIV: begin
            dp_cmd.op = rlss_pkg::DP_DIV;
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = rlss_pkg::ST_DIVEND;
            end
         end
         rlss_pkg::ST_DIVEND: begin
            dp_cmd.op = rlss_pkg::DP_DIVEND;
            if (axis_ff == 2'd2) begin
               state_in = rlss_pkg::ST_APPLY;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = rlss_pkg::ST_DIVINIT;
            end
         end
         rlss_pkg::ST_APPLY: begin
            if (!dp_status.rsp_busy) begin
               dp_cmd.op = rlss_pkg::DP_APPLY;
               state_in  = rlss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rlss_dp.sv =====
// ============================================================================
// rlss_dp
// Datapath of the smoother: position state, configuration registers, one
// shared 32x32 multiplier, square root and divider registers, result register.
// ============================================================================
`default_nettype none

module rlss_dp #(
   parameter int POS_WIDTH = rlss_pkg::POS_WIDTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire [rlss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [rlss_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  wire                                  in_op,
   input  wire [POS_WIDTH-1:0]                  in_pos [3],
   input  rlss_pkg::dp_cmd_type                 dp_cmd,
   output rlss_pkg::dp_status_type              dp_status,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [POS_WIDTH-1:0]                 out_cmd [3],
   output logic                                 out_clamped,
   output logic                                 out_holding
);

   localparam int NCH  = (POS_WIDTH + 1 + 15) / 16;
   localparam int AW   = NCH * 16;
   localparam int ACCW = AW + 16;
   localparam int MAGW = (POS_WIDTH + 1 > 24) ? POS_WIDTH + 1 : 24;
   localparam int SW   = MAGW + 2;
   localparam logic signed [SW-1:0] PMAX =
      $signed({{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}});
   localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

   logic [15:0] gain_ff;
   logic [23:0] limit_ff;
   logic [15:0] timeout_ff;

   logic                 op_ff;
   logic [POS_WIDTH-1:0] in_ff  [3];
   logic [POS_WIDTH-1:0] cmd_ff [3];
   logic [POS_WIDTH-1:0] tgt_ff [3];
   logic                 seen_ff, started_ff, fresh_ff, clamped_ff;
   logic [15:0]          age_ff;

   logic [AW-1:0]   a_ff;
   logic [ACCW-1:0] acc_ff;
   logic [MAGW-1:0] mag_ff [3];
   logic            neg_ff [3];
   logic [63:0]     sum_ff;
   logic [63:0]     rem_ff, res_ff, bit_ff;
   logic [31:0]     len_ff;
   logic [32:0]     drem_ff;
   logic [23:0]     dlo_ff;

   logic                 rsp_valid_ff;
   logic [POS_WIDTH-1:0] out_cmd_ff [3];
   logic                 out_clamped_ff, out_holding_ff;

   // Selected axis and derived values.
   logic [POS_WIDTH-1:0]        tsel;
   logic signed [POS_WIDTH:0]   diff;
   logic [POS_WIDTH:0]          diff_abs;
   logic [63:0]                 sel_mag64;
   logic [29:0]                 sel_r;
   logic [MAGW-1:0]             max01, maxmag;
   logic [63:0]                 maxmag64;
   logic [31:0]                 mul_a, mul_b;
   logic [63:0]                 prod;
   logic [ACCW:0]               acc_round;
   logic [63:0]                 root_try;
   logic [32:0]                 div_try;
   logic signed [SW-1:0]        nv [3];

   assign tsel     = fresh_ff ? tgt_ff[dp_cmd.axis] : cmd_ff[dp_cmd.axis];
   assign diff     = $signed({tsel[POS_WIDTH-1], tsel})
                   - $signed({cmd_ff[dp_cmd.axis][POS_WIDTH-1], cmd_ff[dp_cmd.axis]});
   assign diff_abs = diff[POS_WIDTH] ? (~diff + 1'b1) : diff;
   assign sel_mag64 = 64'(mag_ff[dp_cmd.axis]);
   assign sel_r     = sel_mag64[29:0];
   assign max01     = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign maxmag    = (max01 > mag_ff[2]) ? max01 : mag_ff[2];
   assign maxmag64  = 64'(maxmag);
   assign acc_round = (ACCW + 1)'(acc_ff) + (ACCW + 1)'(32768);
   assign root_try  = res_ff + bit_ff;
   assign div_try   = {drem_ff[31:0], dlo_ff[23]};

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (dp_cmd.op)
         rlss_pkg::DP_GMUL: begin
            mul_a = 32'(a_ff[AW-1 -: 16]);
            mul_b = 32'(gain_ff);
         end
         rlss_pkg::DP_SQ: begin
            mul_a = 32'(sel_mag64[23:0]);
            mul_b = 32'(sel_mag64[23:0]);
         end
         rlss_pkg::DP_SQCMP: begin
            mul_a = 32'(limit_ff);
            mul_b = 32'(limit_ff);
         end
         rlss_pkg::DP_RSQ: begin
            mul_a = 32'(sel_r);
            mul_b = 32'(sel_r);
         end
         rlss_pkg::DP_CEIL: begin
            mul_a = res_ff[31:0];
            mul_b = res_ff[31:0];
         end
         rlss_pkg::DP_DIVINIT: begin
            mul_a = 32'(sel_r);
            mul_b = 32'(limit_ff);
         end
         default: begin
            mul_a = 32'd0;
         end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nv[i] = neg_ff[i]
               ? SW'($signed(cmd_ff[i])) - $signed(SW'(mag_ff[i]))
               : SW'($signed(cmd_ff[i])) + $signed(SW'(mag_ff[i]));
         if (nv[i] > PMAX) begin
            nv[i] = PMAX;
         end else if (nv[i] < PMIN) begin
            nv[i] = PMIN;
         end
      end
   end

   assign dp_status.is_tick    = (op_ff == rlss_pkg::OP_TICK);
   assign dp_status.over_limit = maxmag64 > 64'(limit_ff);
   assign dp_status.sum_over   = sum_ff > prod;
   assign dp_status.need_shift = maxmag64 >= (64'd1 << 30);
   assign dp_status.rsp_busy   = rsp_valid_ff && !rsp_tready;

   // Configuration and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= rlss_pkg::GAIN_RESET;
         limit_ff   <= rlss_pkg::LIMIT_RESET;
         timeout_ff <= rlss_pkg::TIMEOUT_RESET;
         seen_ff    <= 1'b0;
         started_ff <= 1'b0;
         age_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rlss_pkg::REG_SMOOTHING_GAIN: gain_ff    <= csr_wdata[15:0];
               rlss_pkg::REG_STEP_LIMIT:     limit_ff   <= csr_wdata;
               rlss_pkg::REG_TIMEOUT_TICKS:  timeout_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (dp_cmd.op == rlss_pkg::DP_PREP) begin
            if (op_ff == rlss_pkg::OP_TARGET) begin
               seen_ff <= 1'b1;
               age_ff  <= 16'd0;
            end else begin
               started_ff <= 1'b1;
               if (age_ff != 16'hFFFF) begin
                  age_ff <= age_ff + 16'd1;
               end
            end
         end
         if (dp_cmd.op == rlss_pkg::DP_APPLY) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         rlss_pkg::DP_CAPTURE: begin
            op_ff <= in_op;
            for (int i = 0; i < 3; i++) begin
               in_ff[i] <= in_pos[i];
            end
         end
         rlss_pkg::DP_PREP: begin
            fresh_ff   <= seen_ff && (age_ff < timeout_ff);
            clamped_ff <= 1'b0;
            for (int i = 0; i < 3; i++) begin
               if (op_ff == rlss_pkg::OP_TARGET) begin
                  tgt_ff[i] <= in_ff[i];
               end else if (!started_ff) begin
                  cmd_ff[i] <= in_ff[i];
               end
            end
         end
         rlss_pkg::DP_DIFF: begin
            a_ff   <= AW'(diff_abs);
            acc_ff <= '0;
            neg_ff[dp_cmd.axis] <= diff[POS_WIDTH];
         end
         rlss_pkg::DP_GMUL: begin
            acc_ff <= (acc_ff << 16) + ACCW'(prod);
            a_ff   <= a_ff << 16;
         end
         rlss_pkg::DP_GEND: begin
            mag_ff[dp_cmd.axis] <= MAGW'(acc_round >> 16);
         end
         rlss_pkg::DP_CHECK: begin
            clamped_ff <= dp_status.over_limit;
            sum_ff     <= 64'd0;
         end
         rlss_pkg::DP_SQ, rlss_pkg::DP_RSQ: begin
            sum_ff <= sum_ff + prod;
         end
         rlss_pkg::DP_SQCMP: begin
            clamped_ff <= dp_status.sum_over;
            sum_ff     <= 64'd0;
         end
         rlss_pkg::DP_NORM: begin
            if (dp_status.need_shift) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end
         end
         rlss_pkg::DP_ROOTINIT: begin
            rem_ff <= sum_ff;
            res_ff <= 64'd0;
            bit_ff <= 64'd1 << 62;
         end
         rlss_pkg::DP_ROOT: begin
            if (rem_ff >= root_try) begin
               rem_ff <= rem_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         rlss_pkg::DP_CEIL: begin
            // Round the floor root up when it falls short of the sum.
            len_ff <= res_ff[31:0] + 32'(prod < sum_ff);
         end
         rlss_pkg::DP_DIVINIT: begin
            drem_ff <= 33'(prod[53:24]);
            dlo_ff  <= prod[23:0];
         end
         rlss_pkg::DP_DIV: begin
            if (div_try >= {1'b0, len_ff}) begin
               drem_ff <= div_try - {1'b0, len_ff};
               dlo_ff  <= {dlo_ff[22:0], 1'b1};
            end else begin
               drem_ff <= div_try;
               dlo_ff  <= {dlo_ff[22:0], 1'b0};
            end
         end
         rlss_pkg::DP_DIVEND: begin
            mag_ff[dp_cmd.axis] <= (len_ff == 32'd0) ? '0 : MAGW'(dlo_ff);
         end
         rlss_pkg::DP_APPLY: begin
            for (int i = 0; i < 3; i++) begin
               cmd_ff[i]     <= POS_WIDTH'(nv[i]);
               out_cmd_ff[i] <= POS_WIDTH'(nv[i]);
            end
            out_clamped_ff <= clamped_ff;
            out_holding_ff <= !fresh_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign out_cmd     = out_cmd_ff;
   assign out_clamped = out_clamped_ff;
   assign out_holding = out_holding_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rate_limited_setpoint_smoother_core.sv =====
// ============================================================================
// rate_limited_setpoint_smoother_core
// Smooths a 3-axis position setpoint with a first-order filter whose step
// length per control tick is limited.
// ============================================================================
//  channel | direction | tdata (low bit up)           | tuser
//  req     | in        | pos_x, pos_y, pos_z          | operation
//  rsp     | out       | cmd_x, cmd_y, cmd_z          | step_clamped, holding
//  csr     | in        | csr_index, csr_wdata         | -
//
// A target item yields no result. A tick whose step is not limited runs the
// difference and gain of each axis, the squared length check and the update.
// A limited step adds the length normalization, which halves all magnitudes
// until the largest is below 2^30, the 32-step square root and three 24-step
// divisions. The datapath shares one multiplier and uses a bit-serial square
// root and divider.
// Reset is synchronous and clears the controller, the configuration and the
// position state flags; the data registers are always loaded before use.
// A new item is taken while the last result waits in the output register;
// a tick stalls in its final cycle until that register is free.
`default_nettype none

module rate_limited_setpoint_smoother_core #(
   parameter int POS_WIDTH = rlss_pkg::POS_WIDTH_DEFAULT,
   localparam int DW = ((3 * POS_WIDTH + 7) / 8) * 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [DW-1:0]                        req_tdata,  // pos_x, pos_y, pos_z
   input  wire                                 req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [DW-1:0]                       rsp_tdata,  // cmd_x, cmd_y, cmd_z
   output logic [1:0]                          rsp_tuser,  // step_clamped, holding
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [rlss_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [rlss_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   rlss_pkg::dp_cmd_type    dp_cmd;
   rlss_pkg::dp_status_type dp_status;
   logic [POS_WIDTH-1:0]    in_pos  [3];
   logic [POS_WIDTH-1:0]    out_cmd [3];
   logic                    out_clamped, out_holding;

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_pos[i] = req_tdata[i*POS_WIDTH +: POS_WIDTH];
      end
   end

   assign rsp_tdata = DW'({out_cmd[2], out_cmd[1], out_cmd[0]});
   assign rsp_tuser = {out_holding, out_clamped};

   rlss_ctrl #(
      .POS_WIDTH (POS_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   rlss_dp #(
      .POS_WIDTH (POS_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_op       (req_tuser),
      .in_pos      (in_pos),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_cmd     (out_cmd),
      .out_clamped (out_clamped),
      .out_holding (out_holding)
   );

endmodule

`default_nettype wire
